>>> design/etfp_pkg.sv
// ============================================================================
// etfp_pkg - shared types and constants for the escape-time fractal pixel
// Fixed-point format, register indexes and the item structs of both sides.
// ============================================================================
`default_nettype none

package etfp_pkg;

    localparam int FRAC_BITS  = 28;
    localparam int ITER_BITS  = 16;
    localparam int COORD_BITS = 12;
    localparam int VAL_BITS   = 32;
    localparam int PROD_BITS  = 2 * VAL_BITS;
    // a square scaled back by FRAC_BITS, always non-negative
    localparam int SQ_BITS    = PROD_BITS - FRAC_BITS;
    localparam int WIDE_BITS  = PROD_BITS + 2;
    localparam int IDX_BITS   = 3;

    typedef enum logic [IDX_BITS-1:0] {
        REG_MODE       = 3'd0,
        REG_RE_ORIGIN  = 3'd1,
        REG_IM_ORIGIN  = 3'd2,
        REG_RE_STEP    = 3'd3,
        REG_IM_STEP    = 3'd4,
        REG_JULIA_C_RE = 3'd5,
        REG_JULIA_C_IM = 3'd6,
        REG_ITER_LIMIT = 3'd7
    } reg_index_t;

    localparam logic MODE_JULIA      = 1'b0;
    localparam logic MODE_MANDELBROT = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] pixel_col;
        logic [COORD_BITS-1:0] pixel_row;
    } pixel_in_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] out_col;
        logic [COORD_BITS-1:0] out_row;
        logic [ITER_BITS-1:0]  iter_count;
        logic                  inside_res;
    } pixel_out_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [VAL_BITS-1:0] sat32(input logic signed [WIDE_BITS-1:0] v);
        logic signed [VAL_BITS-1:0] r;
        if (v[WIDE_BITS-1:VAL_BITS-1] == {(WIDE_BITS-VAL_BITS+1){1'b0}} ||
            v[WIDE_BITS-1:VAL_BITS-1] == {(WIDE_BITS-VAL_BITS+1){1'b1}})
        begin
            r = v[VAL_BITS-1:0];
        end
        else if (v[WIDE_BITS-1])
        begin
            r = {1'b1, {(VAL_BITS-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(VAL_BITS-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> design/escape_time_fractal_pixel.sv
// ============================================================================
// escape_time_fractal_pixel - Mandelbrot / Julia escape-time evaluator
// Maps one pixel to the complex plane and iterates z = z^2 + c in Q4.28.
// ============================================================================
// A pixel is accepted when start is high and busy is low. One signed 32x32
// multiplier is shared by every product: mapping runs through states MRE,
// MIM and MSET, each iteration through SQR, SQI, TEST and UPD (zr^2, zi^2,
// escape test with zr*zi, update), and the final squares and test through
// SQR, SQI and TEST. The result appears for one cycle with result_valid in
// the same cycle in which busy falls, and a new pixel may be started then.
// Results cannot be stalled. Configuration writes are always ready and must
// be made only while the block is idle.
`default_nettype none

module escape_time_fractal_pixel (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    output logic                                  busy,
    input  wire etfp_pkg::pixel_in_t              pixel,
    input  wire                                   cfg_valid,
    output logic                                  cfg_ready,
    input  wire [etfp_pkg::IDX_BITS-1:0]          cfg_index,
    input  wire [etfp_pkg::VAL_BITS-1:0]          cfg_data,
    output logic                                  result_valid,
    output etfp_pkg::pixel_out_t                  result
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MRE  = 8'b0000_0010,
        S_MIM  = 8'b0000_0100,
        S_MSET = 8'b0000_1000,
        S_SQR  = 8'b0001_0000,
        S_SQI  = 8'b0010_0000,
        S_TEST = 8'b0100_0000,
        S_UPD  = 8'b1000_0000
    } state_t;

    localparam int VB = etfp_pkg::VAL_BITS;
    localparam int WB = etfp_pkg::WIDE_BITS;
    localparam int SB = etfp_pkg::SQ_BITS;
    localparam logic signed [WB-1:0] FOUR = WB'(4) <<< etfp_pkg::FRAC_BITS;

    // configuration registers
    logic                          mode_reg;
    logic signed [VB-1:0]          re_origin_reg, im_origin_reg;
    logic signed [VB-1:0]          re_step_reg, im_step_reg;
    logic signed [VB-1:0]          julia_c_re_reg, julia_c_im_reg;
    logic [etfp_pkg::ITER_BITS-1:0] iter_limit_reg;

    // datapath
    state_t                        state_reg, state_next;
    logic [etfp_pkg::COORD_BITS-1:0] col_reg, row_reg;
    logic signed [VB-1:0]          zr_reg, zi_reg, cr_reg, ci_reg, pre_reg;
    logic signed [etfp_pkg::PROD_BITS-1:0] prod_reg;
    logic signed [SB-1:0]          sr_reg, si_reg;
    logic [etfp_pkg::ITER_BITS-1:0] count_reg;
    logic                          result_valid_reg;
    etfp_pkg::pixel_out_t          result_reg;

    logic signed [VB-1:0]          mul_a, mul_b;
    logic signed [etfp_pkg::PROD_BITS-1:0] mul_p;
    logic signed [VB-1:0]          pim;
    logic signed [SB-1:0]          sq_now;
    logic signed [WB-1:0]          cross_prod;
    logic                          keep_going;

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg != S_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_MRE:
            begin
                mul_a = $signed({{(VB-etfp_pkg::COORD_BITS){1'b0}}, col_reg});
                mul_b = re_step_reg;
            end
            S_MIM:
            begin
                mul_a = $signed({{(VB-etfp_pkg::COORD_BITS){1'b0}}, row_reg});
                mul_b = im_step_reg;
            end
            S_SQR:
            begin
                mul_a = zr_reg;
                mul_b = zr_reg;
            end
            S_SQI:
            begin
                mul_a = zi_reg;
                mul_b = zi_reg;
            end
            default:
            begin
                mul_a = zr_reg;
                mul_b = zi_reg;
            end
        endcase
    end

    assign mul_p  = mul_a * mul_b;
    assign pim    = etfp_pkg::sat32(WB'(im_origin_reg) + WB'(prod_reg));
    assign sq_now = SB'(prod_reg >>> etfp_pkg::FRAC_BITS);
    assign cross_prod = WB'(prod_reg >>> (etfp_pkg::FRAC_BITS - 1));
    assign keep_going = ((WB'(sr_reg) + WB'(sq_now)) < FOUR) && (count_reg < iter_limit_reg);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (start) state_next = S_MRE;
            S_MRE:   state_next = S_MIM;
            S_MIM:   state_next = S_MSET;
            S_MSET:  state_next = S_SQR;
            S_SQR:   state_next = S_SQI;
            S_SQI:   state_next = S_TEST;
            S_TEST:  state_next = keep_going ? S_UPD : S_IDLE;
            S_UPD:   state_next = S_SQR;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            mode_reg         <= etfp_pkg::MODE_MANDELBROT;
            re_origin_reg    <= -32'sd536870912;
            im_origin_reg    <= -32'sd536870912;
            re_step_reg      <= 32'sd1048576;
            im_step_reg      <= 32'sd1048576;
            julia_c_re_reg   <= '0;
            julia_c_im_reg   <= '0;
            iter_limit_reg   <= 16'd100;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= (state_reg == S_TEST) && !keep_going;
            if (cfg_valid)
            begin
                case (etfp_pkg::reg_index_t'(cfg_index))
                    etfp_pkg::REG_MODE:       mode_reg       <= cfg_data[0];
                    etfp_pkg::REG_RE_ORIGIN:  re_origin_reg  <= $signed(cfg_data);
                    etfp_pkg::REG_IM_ORIGIN:  im_origin_reg  <= $signed(cfg_data);
                    etfp_pkg::REG_RE_STEP:    re_step_reg    <= $signed(cfg_data);
                    etfp_pkg::REG_IM_STEP:    im_step_reg    <= $signed(cfg_data);
                    etfp_pkg::REG_JULIA_C_RE: julia_c_re_reg <= $signed(cfg_data);
                    etfp_pkg::REG_JULIA_C_IM: julia_c_im_reg <= $signed(cfg_data);
                    etfp_pkg::REG_ITER_LIMIT: iter_limit_reg <= cfg_data[etfp_pkg::ITER_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (state_reg != S_IDLE)
        begin
            prod_reg <= mul_p;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    col_reg <= pixel.pixel_col;
                    row_reg <= pixel.pixel_row;
                end
            end
            S_MIM:
            begin
                pre_reg <= etfp_pkg::sat32(WB'(re_origin_reg) + WB'(prod_reg));
            end
            S_MSET:
            begin
                count_reg <= '0;
                if (mode_reg == etfp_pkg::MODE_MANDELBROT)
                begin
                    zr_reg <= '0;
                    zi_reg <= '0;
                    cr_reg <= pre_reg;
                    ci_reg <= pim;
                end
                else
                begin
                    zr_reg <= pre_reg;
                    zi_reg <= pim;
                    cr_reg <= julia_c_re_reg;
                    ci_reg <= julia_c_im_reg;
                end
            end
            S_SQI:
            begin
                sr_reg <= sq_now;
            end
            S_TEST:
            begin
                si_reg <= sq_now;
                if (!keep_going)
                begin
                    result_reg.out_col    <= col_reg;
                    result_reg.out_row    <= row_reg;
                    result_reg.iter_count <= count_reg;
                    result_reg.inside_res <= (count_reg == iter_limit_reg);
                end
            end
            S_UPD:
            begin
                // prod_reg holds zr*zi here
                zi_reg    <= etfp_pkg::sat32(cross_prod + WB'(ci_reg));
                zr_reg    <= etfp_pkg::sat32(WB'(sr_reg) - WB'(si_reg) + WB'(cr_reg));
                count_reg <= count_reg + 1'b1;
            end
            default: ;
        endcase
    end

    a_strobe_after_test: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(state_reg == S_TEST))
        else $error("result strobe without a finished escape test");

    a_start_maps: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == S_MRE))
        else $error("accepted pixel did not enter mapping");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> (count_reg <= iter_limit_reg))
        else $error("iteration count passed the limit");

endmodule

`default_nettype wire

>>> tb/sv/fractal_pixel_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fractal_pixel_checker - result checker for the escape-time fractal pixel
// Follows every register write, predicts the escape count of each accepted
// pixel and compares every result with the oldest prediction, field by field.
// ============================================================================
module fractal_pixel_checker (
    input  wire                                   clk,
    input  wire                                   rst_n,
    input  wire                                   start,
    input  wire                                   busy,
    input  etfp_pkg::pixel_in_t                   pixel,
    input  wire                                   cfg_valid,
    input  wire                                   cfg_ready,
    input  wire [etfp_pkg::IDX_BITS-1:0]          cfg_index,
    input  wire [etfp_pkg::VAL_BITS-1:0]          cfg_data,
    input  wire                                   result_valid,
    input  etfp_pkg::pixel_out_t                  result,
    output int                                    mismatches,
    output int                                    outstanding,
    output int                                    checked,
    output int                                    inside_seen
);
    import etfp_pkg::*;

    localparam longint Q_MAX = 2147483647;
    localparam longint Q_MIN = -Q_MAX - 1;

    logic        set_mode;
    int          set_re_origin;
    int          set_im_origin;
    int          set_re_step;
    int          set_im_step;
    int          set_c_re;
    int          set_c_im;
    int unsigned set_limit;

    pixel_out_t  expected_pixels[$];
    pixel_out_t  want;

    function automatic longint clamp_q(input longint v);
        if (v > Q_MAX)
        begin
            return Q_MAX;
        end
        if (v < Q_MIN)
        begin
            return Q_MIN;
        end
        return v;
    endfunction

    // scale a square back to Q4.28, kept wide for the escape test
    function automatic longint square_q(input longint a);
        return (a * a) >>> FRAC_BITS;
    endfunction

    function automatic pixel_out_t predict_escape(input pixel_in_t p);
        longint      col;
        longint      row;
        longint      pre;
        longint      pim;
        longint      zr;
        longint      zi;
        longint      cr;
        longint      ci;
        longint      sr;
        longint      si;
        longint      prod_ri;
        longint      escape_sq;
        int unsigned n;
        pixel_out_t  r;
        col       = longint'(p.pixel_col);
        row       = longint'(p.pixel_row);
        escape_sq = longint'(4) <<< FRAC_BITS;
        pre = clamp_q(longint'(set_re_origin) + col * longint'(set_re_step));
        pim = clamp_q(longint'(set_im_origin) + row * longint'(set_im_step));
        if (set_mode == MODE_MANDELBROT)
        begin
            zr = 0;
            zi = 0;
            cr = pre;
            ci = pim;
        end
        else
        begin
            zr = pre;
            zi = pim;
            cr = longint'(set_c_re);
            ci = longint'(set_c_im);
        end
        sr = square_q(zr);
        si = square_q(zi);
        n  = 0;
        while (sr + si < escape_sq && n < set_limit)
        begin
            // 2*zr*zi: shift one bit less than a plain product
            prod_ri = (zr * zi) >>> (FRAC_BITS - 1);
            zi = clamp_q(prod_ri + ci);
            zr = clamp_q(sr - si + cr);
            sr = square_q(zr);
            si = square_q(zi);
            n++;
        end
        r.out_col    = p.pixel_col;
        r.out_row    = p.pixel_row;
        r.iter_count = n[ITER_BITS-1:0];
        r.inside_res = (n == set_limit);
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned exp_v,
                               input int unsigned act_v);
        if (exp_v != act_v)
        begin
            $error("pixel result field %s: expected %0d, actual %0d", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_mode      = MODE_MANDELBROT;
            set_re_origin = -536870912;
            set_im_origin = -536870912;
            set_re_step   = 1048576;
            set_im_step   = 1048576;
            set_c_re      = 0;
            set_c_im      = 0;
            set_limit     = 100;
            expected_pixels.delete();
            mismatches    = 0;
            outstanding   = 0;
            checked       = 0;
            inside_seen   = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_MODE:       set_mode      = cfg_data[0];
                    REG_RE_ORIGIN:  set_re_origin = cfg_data;
                    REG_IM_ORIGIN:  set_im_origin = cfg_data;
                    REG_RE_STEP:    set_re_step   = cfg_data;
                    REG_IM_STEP:    set_im_step   = cfg_data;
                    REG_JULIA_C_RE: set_c_re      = cfg_data;
                    REG_JULIA_C_IM: set_c_im      = cfg_data;
                    REG_ITER_LIMIT: set_limit     = cfg_data[ITER_BITS-1:0];
                    default: ;
                endcase
            end
            if (result_valid)
            begin
                if (expected_pixels.size() == 0)
                begin
                    $error("result with no pixel waiting: col %0d row %0d",
                           result.out_col, result.out_row);
                    mismatches++;
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    check_field("out_col", want.out_col, result.out_col);
                    check_field("out_row", want.out_row, result.out_row);
                    check_field("iter_count", want.iter_count, result.iter_count);
                    check_field("inside_res", want.inside_res, result.inside_res);
                    checked++;
                    if (result.inside_res)
                    begin
                        inside_seen++;
                    end
                end
            end
            if (start && !busy)
            begin
                expected_pixels.push_back(predict_escape(pixel));
            end
            outstanding = expected_pixels.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - stimulus and verdict for the escape-time fractal pixel
// Directed pixels over reset, zero and maximum limits and saturating points in
// both modes, then random pixels over random register settings with random
// sender gaps. A separate checker predicts and compares every result.
// ============================================================================
module tb;
    import etfp_pkg::*;

    localparam int WATCHDOG_CYCLES  = 1_100_000;
    localparam int PHASES           = 8;
    localparam int PIXELS_PER_PHASE = 240;
    localparam int TAIL_CYCLES      = 300;

    localparam logic [VAL_BITS-1:0] Q_MAX        = 32'h7FFF_FFFF;
    localparam logic [VAL_BITS-1:0] Q_MIN        = 32'h8000_0000;
    localparam logic [VAL_BITS-1:0] ORIGIN_M2    = 32'hE000_0000;
    localparam logic [VAL_BITS-1:0] STEP_1_256   = 32'h0010_0000;
    localparam logic [VAL_BITS-1:0] Q_1P4        = 32'd375809638;
    localparam logic [VAL_BITS-1:0] Q_M1P4       = -32'sd375809638;
    localparam logic [VAL_BITS-1:0] JULIA_RE     = -32'sd214748365;
    localparam logic [VAL_BITS-1:0] JULIA_IM     = 32'd41875931;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    pixel_in_t             pixel;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [IDX_BITS-1:0]   cfg_index;
    logic [VAL_BITS-1:0]   cfg_data;
    logic                  result_valid;
    pixel_out_t            result;

    int mismatches;
    int outstanding;
    int checked;
    int inside_seen;
    int pixels_sent;
    int reg_writes;
    int settings;
    int quiet_cycles;
    int idle_pct;

    escape_time_fractal_pixel DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

    fractal_pixel_checker pixel_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pixel        (pixel),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .checked      (checked),
        .inside_seen  (inside_seen)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // a single in-set pixel at the largest limit keeps busy high without a handshake
    always @(posedge clk)
    begin
        if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles + 1 >= WATCHDOG_CYCLES)
        begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_CYCLES);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic write_reg(input reg_index_t idx, input logic [VAL_BITS-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        reg_writes++;
    endtask

    // hold start low until every predicted result has come back
    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic send_pixel(input logic [COORD_BITS-1:0] col,
                              input logic [COORD_BITS-1:0] row, input int gap);
        @(negedge clk);
        start           = 1'b1;
        pixel.pixel_col = col;
        pixel.pixel_row = row;
        do @(posedge clk); while (busy);
        pixels_sent++;
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic apply_setting(input logic mode, input logic [VAL_BITS-1:0] re_o,
                                 input logic [VAL_BITS-1:0] im_o,
                                 input logic [VAL_BITS-1:0] re_s,
                                 input logic [VAL_BITS-1:0] im_s,
                                 input logic [VAL_BITS-1:0] c_re,
                                 input logic [VAL_BITS-1:0] c_im,
                                 input logic [ITER_BITS-1:0] lim);
        wait_drained();
        write_reg(REG_MODE, {{(VAL_BITS-1){1'b0}}, mode});
        write_reg(REG_RE_ORIGIN, re_o);
        write_reg(REG_IM_ORIGIN, im_o);
        write_reg(REG_RE_STEP, re_s);
        write_reg(REG_IM_STEP, im_s);
        write_reg(REG_JULIA_C_RE, c_re);
        write_reg(REG_JULIA_C_IM, c_im);
        write_reg(REG_ITER_LIMIT, {{(VAL_BITS-ITER_BITS){1'b0}}, lim});
        settings++;
    endtask

    // mostly a window around the sets, a quarter fully random
    task automatic random_setting(input int phase);
        logic                  mode;
        logic [VAL_BITS-1:0]   re_o;
        logic [VAL_BITS-1:0]   im_o;
        logic [VAL_BITS-1:0]   re_s;
        logic [VAL_BITS-1:0]   im_s;
        logic [VAL_BITS-1:0]   c_re;
        logic [VAL_BITS-1:0]   c_im;
        logic [ITER_BITS-1:0]  lim;
        mode = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 3) == 0)
        begin
            re_o = $urandom();
            im_o = $urandom();
            re_s = $urandom();
            im_s = $urandom();
            c_re = $urandom();
            c_im = $urandom();
        end
        else
        begin
            re_o = 32'($urandom_range(0, 939524096)) - 32'd671088640;
            im_o = 32'($urandom_range(0, 805306368)) - 32'd402653184;
            re_s = 32'($urandom_range(4096, 262144));
            im_s = 32'($urandom_range(4096, 262144));
            if ($urandom_range(0, 1))
            begin
                re_s = -re_s;
            end
            if ($urandom_range(0, 1))
            begin
                im_s = -im_s;
            end
            c_re = 32'($urandom_range(0, 536870912)) - 32'd268435456;
            c_im = 32'($urandom_range(0, 536870912)) - 32'd268435456;
        end
        lim = (phase == 0) ? 16'd1 : 16'($urandom_range(2, 64));
        apply_setting(mode, re_o, im_o, re_s, im_s, c_re, c_im, lim);
    endtask

    function automatic logic [COORD_BITS-1:0] random_coord();
        if ($urandom_range(0, 7) == 0)
        begin
            return $urandom_range(0, 1) ? {COORD_BITS{1'b1}} : {COORD_BITS{1'b0}};
        end
        return COORD_BITS'($urandom_range(0, (1 << COORD_BITS) - 1));
    endfunction

    initial
    begin
        int gap;
        start       = 1'b0;
        pixel       = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        rst_n       = 1'b0;
        pixels_sent = 0;
        reg_writes  = 0;
        settings    = 1;
        repeat (11) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: corners, bit patterns, a point inside the set
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd4095, 12'd4095, 0);
        send_pixel(12'd0, 12'd4095, 2);
        send_pixel(12'd4095, 12'd0, 0);
        send_pixel(12'hAAA, 12'h555, 5);
        send_pixel(12'h555, 12'hAAA, 0);
        send_pixel(12'd512, 12'd512, 1);
        send_pixel(12'd448, 12'd512, 0);

        // zero limit: nothing iterates, every pixel counts as inside
        apply_setting(MODE_MANDELBROT, ORIGIN_M2, ORIGIN_M2, STEP_1_256, STEP_1_256,
                      '0, '0, 16'd0);
        send_pixel(12'd512, 12'd512, 0);
        send_pixel(12'd0, 12'd0, 0);

        apply_setting(MODE_JULIA, ORIGIN_M2, ORIGIN_M2, STEP_1_256, STEP_1_256,
                      JULIA_RE, JULIA_IM, 16'd1);
        send_pixel(12'd512, 12'd512, 0);
        send_pixel(12'd0, 12'd0, 3);

        apply_setting(MODE_JULIA, ORIGIN_M2, ORIGIN_M2, STEP_1_256, STEP_1_256,
                      JULIA_RE, JULIA_IM, 16'd40);
        send_pixel(12'd600, 12'd540, 0);
        send_pixel(12'd300, 12'd700, 0);
        send_pixel(12'd700, 12'd300, 0);

        // mapped points clamp at both ends
        apply_setting(MODE_MANDELBROT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, '0, '0, 16'd5);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd1, 12'd1, 0);
        apply_setting(MODE_MANDELBROT, Q_MIN, Q_MIN, Q_MIN, Q_MIN, '0, '0, 16'd5);
        send_pixel(12'd4095, 12'd4095, 0);
        send_pixel(12'd0, 12'd0, 0);

        // z update clamps: |z| just under 2 plus an extreme constant
        apply_setting(MODE_JULIA, Q_1P4, Q_1P4, '0, '0, Q_MAX, Q_MAX, 16'd5);
        send_pixel(12'd0, 12'd0, 0);
        apply_setting(MODE_JULIA, Q_1P4, Q_M1P4, '0, '0, Q_MIN, Q_MIN, 16'd5);
        send_pixel(12'd4095, 12'd0, 0);

        // largest limit: c = 0 never escapes, far point escapes after one iteration
        apply_setting(MODE_MANDELBROT, '0, '0, STEP_1_256, STEP_1_256, '0, '0, 16'hFFFF);
        send_pixel(12'd0, 12'd0, 0);
        send_pixel(12'd4095, 12'd4095, 0);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_setting(ph);
            case (ph % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 49;
                2:       idle_pct = 0;
                default: idle_pct = 29;
            endcase
            for (int i = 0; i < PIXELS_PER_PHASE; i++)
            begin
                gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 40) : 0;
                if ($urandom_range(0, 99) < 2)
                begin
                    wait_drained();
                end
                send_pixel(random_coord(), random_coord(), gap);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("Covered %0d pixels over %0d register settings, both modes, limits 0 to 65535",
                 pixels_sent, settings);
        $display("%0d results checked, %0d inside the set, %0d register writes",
                 checked, inside_seen, reg_writes);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
design/etfp_pkg.sv
design/escape_time_fractal_pixel.sv
tb/sv/fractal_pixel_checker.sv
tb/sv/tb.sv
